// ===== rtl/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and codes for the SPI master with FIFOs: item layouts,
// request and register codes, and the bundles passed between the stages.
// ----------------------------------------------------------------------------
package smf_pkg;

	// request codes carried in req_type
	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_WRITE   = 3'd1;
	localparam logic [2:0] REQ_READ    = 3'd2;
	localparam logic [2:0] REQ_STATUS  = 3'd3;
	localparam logic [2:0] REQ_CLR_OVF = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_POLARITY = 3'd1;
	localparam logic [2:0] REG_EDGE     = 3'd2;
	localparam logic [2:0] REG_DIVIDER  = 3'd3;
	localparam logic [2:0] REG_IRQ_SEL  = 3'd4;

	// transmit interrupt sources
	localparam logic [1:0] IRQ_IDLE     = 2'd0;
	localparam logic [1:0] IRQ_EMPTY    = 2'd1;
	localparam logic [1:0] IRQ_HALF     = 2'd2;
	localparam logic [1:0] IRQ_NOT_FULL = 2'd3;

	localparam int          CFG_DATA_W = 16;
	localparam logic [3:0]  BYTE_BITS  = 4'd8;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] write_byte;
		logic       miso_bit;
	} tick_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_empty;
		logic       tx_full;
		logic       rx_empty;
		logic       shift_idle;
		logic       rx_overflow;
		logic       sck_level;
		logic       mosi_level;
		logic       tx_irq;
	} result_item_t;

	typedef struct packed {
		logic [2:0]            index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_item_t;

	// classified bus access
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clr_ovf;
		logic [7:0] wbyte;
		logic       miso;
	} cmd_t;

	typedef struct packed {
		logic       enable;
		logic       polarity;
		logic       edge_sel;
		logic [1:0] irq_sel;
	} cfg_flags_t;

	// shifter datapath operations for one item
	typedef struct packed {
		logic       ld;
		logic       ld_bypass;
		logic [7:0] ld_byte;
		logic       smp;
		logic       mset;
		logic       rx_push;
		logic       rx_pop;
		logic       miso;
	} shift_op_t;

	typedef struct packed {
		logic tx_empty;
		logic tx_full;
		logic rx_empty;
		logic shift_idle;
		logic rx_overflow;
		logic sck_level;
		logic tx_irq;
	} status_t;

endpackage

// ===== rtl/smf_chan_if.sv =====
// ----------------------------------------------------------------------------
// smf_chan_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface smf_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

// ===== rtl/smf_ram.sv =====
// ----------------------------------------------------------------------------
// smf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/smf_front.sv =====
// ----------------------------------------------------------------------------
// smf_front
// Takes tick items, decodes the bus access and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module smf_front (
	input  logic            clk,
	input  logic            arst_n,
	smf_chan_if.sink        tick,
	input  logic            pop,
	output logic            cmd_valid,
	output smf_pkg::cmd_t   cmd
);
	smf_pkg::cmd_t ent_q [2];
	smf_pkg::cmd_t dec;
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          push;

	assign tick.ready = (cnt_q != 2'd2);
	assign push       = tick.valid & tick.ready;
	assign cmd_valid  = (cnt_q != 2'd0);
	assign cmd        = ent_q[rd_q];

	always_comb begin
		dec       = '0;
		dec.wbyte = tick.data.write_byte;
		dec.miso  = tick.data.miso_bit;
		case (tick.data.req_type)
			smf_pkg::REQ_WRITE:   dec.push    = 1'b1;
			smf_pkg::REQ_READ:    dec.pop     = 1'b1;
			smf_pkg::REQ_CLR_OVF: dec.clr_ovf = 1'b1;
			default:              ; // plain tick, status read, unused codes
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== rtl/smf_ctrl.sv =====
// ----------------------------------------------------------------------------
// smf_ctrl
// Back end, first stage: FIFO counts and pointers, serial clock timing and
// bit counting. Owns the TX RAM and issues shifter operations to stage 2.
// ----------------------------------------------------------------------------
module smf_ctrl #(
	parameter int FIFO_DEPTH   = 16,
	parameter int DIVIDER_BITS = 13,
	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
	localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	input  smf_pkg::cmd_t            cmd,
	input  logic                     adv,
	output logic                     fire,
	input  smf_pkg::cfg_flags_t      flags,
	input  logic [DIVIDER_BITS-1:0]  divider,
	input  logic                     clear,
	output logic                     valid_s2,
	output smf_pkg::shift_op_t       op_s2,
	output smf_pkg::status_t         status_s2,
	output logic [AW-1:0]            rx_waddr_s2,
	output logic [AW-1:0]            rx_raddr_s2,
	output logic [7:0]               tx_rdata
);
	localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
	localparam logic [CW-1:0] HALF_C  = CW'(FIFO_DEPTH / 2);
	localparam logic [AW-1:0] LAST_C  = AW'(FIFO_DEPTH - 1);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == LAST_C) ? '0 : p + 1'b1;
	endfunction

	// head plus count, wrapped to the depth
	function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] h, input logic [CW-1:0] c);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(c);
		if (s >= (CW+1)'(FIFO_DEPTH)) begin
			s = s - (CW+1)'(FIFO_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	logic [CW-1:0]           tx_cnt_q, rx_cnt_q;
	logic [AW-1:0]           tx_head_q, rx_head_q;
	logic [3:0]              bc_q;
	logic [DIVIDER_BITS-1:0] tick_q;
	logic                    sck_q;
	logic                    ovf_q;

	logic [CW-1:0]           tx_cnt_a, rx_cnt_a, tx_cnt_n, rx_cnt_n;
	logic [AW-1:0]           rx_head_a, tx_head_n, rx_head_n;
	logic [3:0]              bc_n;
	logic [DIVIDER_BITS-1:0] tick_n;
	logic                    sck_n, ovf_n;
	logic                    en, do_push, do_pop;
	smf_pkg::shift_op_t      op;
	smf_pkg::status_t        st;

	assign fire = adv & cmd_valid;

	always_comb begin
		en        = flags.enable;
		do_push   = en & cmd.push & (tx_cnt_q != DEPTH_C);
		do_pop    = en & cmd.pop & (rx_cnt_q != '0);
		tx_cnt_a  = tx_cnt_q + CW'(do_push);
		rx_cnt_a  = rx_cnt_q - CW'(do_pop);
		rx_head_a = do_pop ? ptr_inc(rx_head_q) : rx_head_q;

		tx_head_n = tx_head_q;
		tx_cnt_n  = tx_cnt_a;
		rx_head_n = rx_head_a;
		rx_cnt_n  = rx_cnt_a;
		bc_n      = bc_q;
		tick_n    = tick_q;
		sck_n     = sck_q;
		ovf_n     = ovf_q & ~(en & cmd.clr_ovf);

		op           = '0;
		op.ld_byte   = cmd.wbyte;
		op.ld_bypass = (tx_cnt_q == '0);
		op.rx_pop    = do_pop;
		op.miso      = cmd.miso;

		if (en) begin
			if (bc_q == '0) begin
				if (tx_cnt_a != '0) begin
					// load next byte; the new half period starts now
					op.ld     = 1'b1;
					op.mset   = flags.edge_sel;
					tx_head_n = ptr_inc(tx_head_q);
					tx_cnt_n  = tx_cnt_a - 1'b1;
					bc_n      = smf_pkg::BYTE_BITS;
					tick_n    = '0;
					sck_n     = 1'b0;
				end
			end else if (tick_q < divider) begin
				tick_n = tick_q + 1'b1;
			end else begin
				tick_n = '0;
				if (!sck_q) begin
					sck_n   = 1'b1;
					op.smp  = flags.edge_sel;
					op.mset = ~flags.edge_sel;
				end else begin
					sck_n  = 1'b0;
					op.smp = ~flags.edge_sel;
					bc_n   = bc_q - 1'b1;
					if (bc_q != 4'd1) begin
						op.mset = flags.edge_sel;
					end else if (rx_cnt_a != DEPTH_C) begin
						op.rx_push = 1'b1;
						rx_cnt_n   = rx_cnt_a + 1'b1;
					end else begin
						ovf_n = 1'b1;
					end
				end
			end
		end

		st.tx_empty    = (tx_cnt_n == '0);
		st.tx_full     = (tx_cnt_n == DEPTH_C);
		st.rx_empty    = (rx_cnt_n == '0);
		st.shift_idle  = (bc_n == '0);
		st.rx_overflow = ovf_n;
		st.sck_level   = sck_n ^ flags.polarity;
		case (flags.irq_sel)
			smf_pkg::IRQ_IDLE:  st.tx_irq = (bc_n == '0);
			smf_pkg::IRQ_EMPTY: st.tx_irq = (tx_cnt_n == '0);
			smf_pkg::IRQ_HALF:  st.tx_irq = (tx_cnt_n <= HALF_C);
			default:            st.tx_irq = (tx_cnt_n != DEPTH_C);
		endcase
	end

	smf_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (fire & do_push),
		.waddr (ptr_add(tx_head_q, tx_cnt_q)),
		.wdata (cmd.wbyte),
		.re    (fire & op.ld & ~op.ld_bypass),
		.raddr (tx_head_q),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_cnt_q  <= '0;
			rx_cnt_q  <= '0;
			tx_head_q <= '0;
			rx_head_q <= '0;
			bc_q      <= '0;
			tick_q    <= '0;
			sck_q     <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (clear) begin
			tx_cnt_q  <= '0;
			rx_cnt_q  <= '0;
			tx_head_q <= '0;
			rx_head_q <= '0;
			bc_q      <= '0;
			tick_q    <= '0;
			sck_q     <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (fire) begin
			tx_cnt_q  <= tx_cnt_n;
			rx_cnt_q  <= rx_cnt_n;
			tx_head_q <= tx_head_n;
			rx_head_q <= rx_head_n;
			bc_q      <= bc_n;
			tick_q    <= tick_n;
			sck_q     <= sck_n;
			ovf_q     <= ovf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2       <= op;
			status_s2   <= st;
			rx_waddr_s2 <= ptr_add(rx_head_a, rx_cnt_a);
			rx_raddr_s2 <= rx_head_q;
		end
	end
endmodule

// ===== rtl/smf_shift.sv =====
// ----------------------------------------------------------------------------
// smf_shift
// Back end, second stage: shift register, MOSI latch and RX RAM, then the
// result register driving the output channel.
// ----------------------------------------------------------------------------
module smf_shift #(
	parameter int FIFO_DEPTH = 16,
	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s2,
	input  smf_pkg::shift_op_t op_s2,
	input  smf_pkg::status_t   status_s2,
	input  logic [AW-1:0]      rx_waddr_s2,
	input  logic [AW-1:0]      rx_raddr_s2,
	input  logic [7:0]         tx_rdata,
	input  logic               clear,
	output logic               adv,
	smf_chan_if.source         result
);
	logic [7:0]            shift_q;
	logic                  mosi_q;
	logic [7:0]            shift_new;
	logic                  mosi_new;
	logic                  step;
	logic                  valid_s3;
	logic                  pop_s3;
	logic                  mosi_s3;
	smf_pkg::status_t      status_s3;
	logic [7:0]            rx_rdata;
	smf_pkg::result_item_t res;

	assign adv  = ~valid_s3 | result.ready;
	assign step = adv & valid_s2;

	always_comb begin
		if (op_s2.ld) begin
			shift_new = op_s2.ld_bypass ? op_s2.ld_byte : tx_rdata;
		end else if (op_s2.smp) begin
			shift_new = {shift_q[6:0], op_s2.miso};
		end else begin
			shift_new = shift_q;
		end
		mosi_new = op_s2.mset ? shift_new[7] : mosi_q;
	end

	smf_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (step & op_s2.rx_push),
		.waddr (rx_waddr_s2),
		.wdata (shift_new),
		.re    (step & op_s2.rx_pop),
		.raddr (rx_raddr_s2),
		.rdata (rx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			mosi_q  <= 1'b0;
		end else if (clear) begin
			shift_q <= '0;
			mosi_q  <= 1'b0;
		end else if (step) begin
			shift_q <= shift_new;
			mosi_q  <= mosi_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s3 <= status_s2;
			pop_s3    <= op_s2.rx_pop;
			mosi_s3   <= mosi_new;
		end
	end

	always_comb begin
		res.read_data   = pop_s3 ? rx_rdata : 8'd0;
		res.tx_empty    = status_s3.tx_empty;
		res.tx_full     = status_s3.tx_full;
		res.rx_empty    = status_s3.rx_empty;
		res.shift_idle  = status_s3.shift_idle;
		res.rx_overflow = status_s3.rx_overflow;
		res.sck_level   = status_s3.sck_level;
		res.mosi_level  = mosi_s3;
		res.tx_irq      = status_s3.tx_irq;
	end

	assign result.valid = valid_s3;
	assign result.data  = res;
endmodule

// ===== rtl/spi_master_fifo_peripheral.sv =====
// ----------------------------------------------------------------------------
// spi_master_fifo_peripheral
// 8-bit MSB-first SPI master, modes 0 to 3, with TX and RX byte FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//  - tick: one item per peripheral clock tick, carrying an optional bus
//    access (write buffer, read buffer, read status, clear overflow) and the
//    sampled MISO level.
//  - result: one item per tick with the popped byte (or zero), FIFO and
//    shifter status, the overflow flag, SCK and MOSI levels and tx_irq.
//  - cfg: register writes (enable, polarity, edge, divider, irq select);
//    always ready, to be used only while no items are in flight.
// Timing: one item per cycle sustained while results are taken. A tick item
//   moves from the input queue through the control stage (counters, clock
//   timing, TX RAM read) into the stage-2 registers, then through the
//   shifter stage (shift register, RX RAM read) into the result register.
// Stalls: a held result freezes the back end; the two-entry input queue
//   keeps taking items until it fills, then tick.ready drops.
// Reset: module disabled, FIFOs empty, shifter idle, SCK idle low, MOSI 0.
//   FIFO storage is not cleared; entries are read only once written.
// Writing enable to 0 clears the FIFOs, shifter, clock phase and overflow.
// ----------------------------------------------------------------------------
module spi_master_fifo_peripheral #(
	parameter int FIFO_DEPTH   = 16,
	parameter int DIVIDER_BITS = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	smf_chan_if.sink    tick,
	smf_chan_if.source  result,
	smf_chan_if.sink    cfg
);
	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	// configuration registers
	smf_pkg::cfg_flags_t     flags_q;
	logic [DIVIDER_BITS-1:0] div_q;
	logic                    cfg_wr;
	logic                    cfg_clear;

	// front to back
	logic                    cmd_valid;
	smf_pkg::cmd_t           cmd;
	logic                    fire;
	logic                    adv;

	// control stage to shifter stage
	logic                    valid_s2;
	smf_pkg::shift_op_t      op_s2;
	smf_pkg::status_t        status_s2;
	logic [AW-1:0]           rx_waddr_s2;
	logic [AW-1:0]           rx_raddr_s2;
	logic [7:0]              tx_rdata;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid & cfg.ready;
	// disabling clears the FIFOs, shifter, clock phase and overflow at once
	assign cfg_clear = cfg_wr & (cfg.data.index == smf_pkg::REG_ENABLE) & ~cfg.data.value[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			div_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg.data.index)
				smf_pkg::REG_ENABLE:   flags_q.enable   <= cfg.data.value[0];
				smf_pkg::REG_POLARITY: flags_q.polarity <= cfg.data.value[0];
				smf_pkg::REG_EDGE:     flags_q.edge_sel <= cfg.data.value[0];
				smf_pkg::REG_DIVIDER:  div_q            <= cfg.data.value[DIVIDER_BITS-1:0];
				smf_pkg::REG_IRQ_SEL:  flags_q.irq_sel  <= cfg.data.value[1:0];
				default:               ; // unknown index, write dropped
			endcase
		end
	end

	// front: accept and decode items into the queue
	smf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.pop       (fire),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	// back, stage 1: counters, pointers, serial clock sequencing
	smf_ctrl #(
		.FIFO_DEPTH   (FIFO_DEPTH),
		.DIVIDER_BITS (DIVIDER_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.adv         (adv),
		.fire        (fire),
		.flags       (flags_q),
		.divider     (div_q),
		.clear       (cfg_clear),
		.valid_s2    (valid_s2),
		.op_s2       (op_s2),
		.status_s2   (status_s2),
		.rx_waddr_s2 (rx_waddr_s2),
		.rx_raddr_s2 (rx_raddr_s2),
		.tx_rdata    (tx_rdata)
	);

	// back, stage 2: shift register, RX storage and result register
	smf_shift #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_shift (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s2    (valid_s2),
		.op_s2       (op_s2),
		.status_s2   (status_s2),
		.rx_waddr_s2 (rx_waddr_s2),
		.rx_raddr_s2 (rx_raddr_s2),
		.tx_rdata    (tx_rdata),
		.clear       (cfg_clear),
		.adv         (adv),
		.result      (result)
	);
endmodule

// ===== rtl/smf_checker.sv =====
// ----------------------------------------------------------------------------
// smf_checker
// Port-level checks on the SPI master, attached to the top level by bind.
// ----------------------------------------------------------------------------
module smf_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  tick_valid,
	input logic                  tick_ready,
	input logic                  result_valid,
	input logic                  result_ready,
	input smf_pkg::result_item_t result_data
);
	// held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// a FIFO cannot be full and empty at once
	a_tx_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result_data.tx_full && result_data.tx_empty))
		else $error("tx_full and tx_empty both set");

	// input back-pressure only follows an output stall
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> $past(result_valid && !result_ready))
		else $error("tick not ready without output stall");

	// nothing comes out straight after reset
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid after reset");
endmodule

bind spi_master_fifo_peripheral smf_checker u_smf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick.valid),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SPI master with FIFOs. Ticks go in through a
// valid/ready channel. A cycle-free mirror of the shifter, FIFOs and clock
// timing predicts every result item, and each result is checked field by
// field as it comes out. Phases cover modes 0 to 3, divider extremes, every
// interrupt source, the RX overflow, a disable, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIFO_DEPTH    = 16;
	localparam int DIVIDER_BITS  = 13;
	localparam int DIV_MAX       = (1 << DIVIDER_BITS) - 1;
	localparam int REQ_LAST      = 7;     // highest code req_type can carry
	localparam int SETTLE_CYCLES = 8;     // three-stage pipe plus margin
	localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake at all
	localparam int PRESSURE_HOLD = 300;   // long receiver hold-off
	localparam int PRINT_CAP     = 40;

	// ------------------------------------------------------------------------
	// Mirror of the peripheral: registers, FIFOs, shifter and clock phase.
	// Each accepted tick advances it once and queues the result it shows.
	// ------------------------------------------------------------------------
	class spi_master_mirror;
		localparam int DEPTH = 16;
		localparam int DIV_W = 13;

		// registers
		bit             en;
		bit             pol;
		bit             edge_sel;
		bit [DIV_W-1:0] div;
		bit [1:0]       irq_sel;

		// datapath
		bit [7:0] tx_q [DEPTH];
		bit [7:0] rx_q [DEPTH];
		int       tx_cnt, rx_cnt, tx_head, rx_head;
		bit [7:0] sreg;
		int       bits_left;
		int       tick_cnt;
		bit       sck_ph;
		bit       ovf;
		bit       mosi;

		smf_pkg::result_item_t due_results[$];
		int                    fails, checked, bytes_in, bytes_dropped;

		function void clear_all();
			tx_cnt = 0; rx_cnt = 0; tx_head = 0; rx_head = 0;
			sreg = '0; bits_left = 0; tick_cnt = 0; sck_ph = 0;
			ovf = 0; mosi = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [smf_pkg::CFG_DATA_W-1:0] v);
			case (idx)
				smf_pkg::REG_ENABLE: begin
					en = v[0];
					if (!en)
						clear_all();
				end
				smf_pkg::REG_POLARITY: pol = v[0];
				smf_pkg::REG_EDGE:     edge_sel = v[0];
				smf_pkg::REG_DIVIDER:  div = v[DIV_W-1:0];
				smf_pkg::REG_IRQ_SEL:  irq_sel = v[1:0];
				default: ;
			endcase
		endfunction

		// one tick of the shifter, after the bus access
		function void shift_step(bit miso);
			if (bits_left == 0) begin
				if (tx_cnt > 0) begin
					sreg = tx_q[tx_head];
					tx_head = (tx_head + 1) % DEPTH;
					tx_cnt--;
					bits_left = 8;
					tick_cnt = 0;
					sck_ph = 0;
					if (edge_sel)
						mosi = sreg[7];
				end
				return;
			end
			if (tick_cnt < div) begin
				tick_cnt++;
				return;
			end
			tick_cnt = 0;
			if (!sck_ph) begin
				sck_ph = 1;
				if (edge_sel)
					sreg = {sreg[6:0], miso};
				else
					mosi = sreg[7];
				return;
			end
			sck_ph = 0;
			if (!edge_sel)
				sreg = {sreg[6:0], miso};
			bits_left--;
			if (bits_left != 0) begin
				if (edge_sel)
					mosi = sreg[7];
				return;
			end
			if (rx_cnt < DEPTH) begin
				rx_q[(rx_head + rx_cnt) % DEPTH] = sreg;
				rx_cnt++;
				bytes_in++;
			end else begin
				ovf = 1;
				bytes_dropped++;
			end
		endfunction

		function void take_tick(smf_pkg::tick_item_t it);
			smf_pkg::result_item_t r;
			r = '0;
			if (!en) begin
				clear_all();
			end else begin
				case (it.req_type)
					smf_pkg::REQ_WRITE: begin
						if (tx_cnt < DEPTH) begin
							tx_q[(tx_head + tx_cnt) % DEPTH] = it.write_byte;
							tx_cnt++;
						end
					end
					smf_pkg::REQ_READ: begin
						if (rx_cnt > 0) begin
							r.read_data = rx_q[rx_head];
							rx_head = (rx_head + 1) % DEPTH;
							rx_cnt--;
						end
					end
					smf_pkg::REQ_CLR_OVF: ovf = 0;
					default: ;
				endcase
				shift_step(it.miso_bit);
			end
			case (irq_sel)
				smf_pkg::IRQ_IDLE:  r.tx_irq = (bits_left == 0);
				smf_pkg::IRQ_EMPTY: r.tx_irq = (tx_cnt == 0);
				smf_pkg::IRQ_HALF:  r.tx_irq = (tx_cnt <= DEPTH / 2);
				default:            r.tx_irq = (tx_cnt < DEPTH);
			endcase
			r.tx_empty    = (tx_cnt == 0);
			r.tx_full     = (tx_cnt >= DEPTH);
			r.rx_empty    = (rx_cnt == 0);
			r.shift_idle  = (bits_left == 0);
			r.rx_overflow = ovf;
			r.sck_level   = sck_ph ^ pol;
			r.mosi_level  = mosi;
			due_results.push_back(r);
		endfunction

		task report(string msg);
			fails++;
			if (fails <= PRINT_CAP)
				$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task match_result(smf_pkg::result_item_t got);
			smf_pkg::result_item_t want;
			logic [7:0]            got_flags, want_flags;
			string                 flag_names[8] = '{"tx_irq", "mosi_level", "sck_level",
				"rx_overflow", "shift_idle", "rx_empty", "tx_full", "tx_empty"};
			if (due_results.size() == 0) begin
				report($sformatf("result %h with nothing due", got));
				return;
			end
			want = due_results.pop_front();
			if (got.read_data !== want.read_data)
				report($sformatf("result %0d read_data %h, want %h",
					checked, got.read_data, want.read_data));
			got_flags = got[7:0];
			want_flags = want[7:0];
			for (int i = 0; i < 8; i++)
				if (got_flags[i] !== want_flags[i])
					report($sformatf("result %0d %s %b, want %b",
						checked, flag_names[i], got_flags[i], want_flags[i]));
			checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	smf_chan_if #(.payload_t(smf_pkg::tick_item_t))   tick_ch ();
	smf_chan_if #(.payload_t(smf_pkg::result_item_t)) result_ch ();
	smf_chan_if #(.payload_t(smf_pkg::cfg_item_t))    cfg_ch ();

	spi_master_fifo_peripheral #(
		.FIFO_DEPTH  (FIFO_DEPTH),
		.DIVIDER_BITS(DIVIDER_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	spi_master_mirror mirror = new();

	// idling odds per phase, in percent
	int snd_gap_pct   = 0;
	int rcv_stall_pct = 0;
	// bumped by the stimulus to ask the receiver for one long hold-off
	int hold_token    = 0;

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------------

	// present one item, with random idle cycles ahead of it, and wait for it
	// to be taken; the mirror sees it at the accepting edge
	task automatic send_tick(smf_pkg::tick_item_t it);
		while ($urandom_range(99) < snd_gap_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.data  <= it;
		do @(posedge clk); while (!tick_ch.ready);
		mirror.take_tick(it);
	endtask

	// random item: writes and reads at the given odds, the rest spread over
	// plain ticks, status reads, overflow clears and the undefined codes
	function automatic smf_pkg::tick_item_t make_tick(int wr_pct, int rd_pct);
		smf_pkg::tick_item_t t;
		int                  roll;
		roll = $urandom_range(99);
		t.write_byte = 8'($urandom);
		t.miso_bit = 1'($urandom);
		if (roll < wr_pct)
			t.req_type = smf_pkg::REQ_WRITE;
		else if (roll < wr_pct + rd_pct)
			t.req_type = smf_pkg::REQ_READ;
		else begin
			case ($urandom_range(4))
				0: t.req_type = smf_pkg::REQ_TICK;
				1: t.req_type = smf_pkg::REQ_STATUS;
				2: t.req_type = smf_pkg::REQ_CLR_OVF;
				default: t.req_type = 3'($urandom_range(REQ_LAST, smf_pkg::REQ_CLR_OVF + 1));
			endcase
		end
		return t;
	endfunction

	task automatic run_phase(int items, int wr_pct, int rd_pct);
		for (int n = 0; n < items; n++)
			send_tick(make_tick(wr_pct, rd_pct));
		tick_ch.valid <= 1'b0;
	endtask

	// wait for every due result, then let the pipe run dry
	task automatic settle();
		while (mirror.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write; bits above the field carry junk, which must be ignored.
	// valid is left high so that writes can go back to back
	task automatic write_reg(logic [2:0] idx, int field, int width);
		logic [smf_pkg::CFG_DATA_W-1:0] mask, v;
		mask = smf_pkg::CFG_DATA_W'((1 << width) - 1);
		v = (smf_pkg::CFG_DATA_W'($urandom) & ~mask) | (smf_pkg::CFG_DATA_W'(field) & mask);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= {idx, v};
		do @(posedge clk); while (!cfg_ch.ready);
		mirror.set_reg(idx, v);
	endtask

	task automatic program_regs(bit en, bit pol, bit edg, int div, logic [1:0] sel);
		write_reg(smf_pkg::REG_ENABLE, en, 1);
		write_reg(smf_pkg::REG_POLARITY, pol, 1);
		write_reg(smf_pkg::REG_EDGE, edg, 1);
		write_reg(smf_pkg::REG_DIVIDER, div, DIVIDER_BITS);
		write_reg(smf_pkg::REG_IRQ_SEL, sel, 2);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: checks each accepted result and stalls at random; a hold-off
	// request takes ready low for a long stretch so the input side backs up.
	// ------------------------------------------------------------------------
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				mirror.match_result(result_ch.data);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = PRESSURE_HOLD;
			end
			if (!arst_n || hold_left > 0) begin
				result_ch.ready <= 1'b0;
				if (hold_left > 0)
					hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	// watchdog: any handshake on any channel counts as progress
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// still disabled after reset: accesses do nothing, outputs stay idle
		run_phase(3, 40, 30);
		settle();

		// mode 1, fastest clock; the unused register indexes must be ignored
		program_regs(1'b1, 1'b0, 1'b0, 0, smf_pkg::IRQ_IDLE);
		for (int i = smf_pkg::REG_IRQ_SEL + 1; i <= REQ_LAST; i++)
			write_reg(3'(i), $urandom, smf_pkg::CFG_DATA_W);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);

		// directed: read of an empty RX FIFO, extreme bytes, every request
		// code including the undefined ones, then enough ticks to finish the
		// first byte and read it back
		send_tick(smf_pkg::tick_item_t'{smf_pkg::REQ_READ, 8'h00, 1'b0});
		send_tick(smf_pkg::tick_item_t'{smf_pkg::REQ_WRITE, 8'h00, 1'b1});
		send_tick(smf_pkg::tick_item_t'{smf_pkg::REQ_WRITE, 8'hFF, 1'b0});
		send_tick(smf_pkg::tick_item_t'{smf_pkg::REQ_WRITE, 8'hA5, 1'b1});
		send_tick(smf_pkg::tick_item_t'{smf_pkg::REQ_STATUS, 8'hFF, 1'b1});
		send_tick(smf_pkg::tick_item_t'{smf_pkg::REQ_CLR_OVF, 8'h00, 1'b0});
		for (int u = smf_pkg::REQ_CLR_OVF + 1; u <= REQ_LAST; u++)
			send_tick(smf_pkg::tick_item_t'{3'(u), 8'h5A, 1'(u)});
		repeat (12)
			send_tick(smf_pkg::tick_item_t'{smf_pkg::REQ_TICK, 8'($urandom), 1'($urandom)});
		repeat (2) send_tick(smf_pkg::tick_item_t'{smf_pkg::REQ_READ, 8'h00, 1'b1});
		tick_ch.valid <= 1'b0;
		settle();

		// write-heavy with no reads: TX fills and drops, RX fills and overflows
		program_regs(1'b1, 1'b0, 1'b1, 0, smf_pkg::IRQ_EMPTY);
		run_phase(300, 75, 0);
		settle();

		// idle-high clock, sender mostly idle, reads drain RX
		program_regs(1'b1, 1'b1, 1'b0, $urandom_range(3, 1), smf_pkg::IRQ_HALF);
		snd_gap_pct = 80;
		run_phase(60, 30, 50);
		settle();

		// slowest clock: a byte sits mid half period, receiver mostly stalled
		program_regs(1'b1, 1'b1, 1'b1, DIV_MAX, smf_pkg::IRQ_NOT_FULL);
		snd_gap_pct = 0;
		rcv_stall_pct = 80;
		run_phase(30, 50, 20);
		settle();

		// divider lowered and polarity changed with that byte in flight
		program_regs(1'b1, 1'b0, 1'b1, 2, 2'($urandom));
		snd_gap_pct = 26;
		rcv_stall_pct = 26;
		run_phase(60, 40, 30);
		settle();

		// pressure: receiver holds off while ticks keep coming
		program_regs(1'b1, 1'($urandom), 1'($urandom), 0, 2'($urandom));
		snd_gap_pct = 0;
		rcv_stall_pct = 0;
		hold_token++;
		run_phase(60, 50, 20);
		settle();

		// disable clears everything; accesses meanwhile are ignored
		program_regs(1'b0, 1'($urandom), 1'($urandom), $urandom_range(2), 2'($urandom));
		run_phase(5, 50, 30);
		settle();

		program_regs(1'b1, 1'($urandom), 1'($urandom), $urandom_range(2), 2'($urandom));
		snd_gap_pct = 26;
		rcv_stall_pct = 26;
		run_phase(60, 45, 35);
		settle();

		$display("covered %0d ticks in modes 0 to 3, dividers 0 to %0d, all irq sources",
			mirror.checked, DIV_MAX);
		$display("%0d bytes received, %0d dropped on RX overflow, %0d mismatches",
			mirror.bytes_in, mirror.bytes_dropped, mirror.fails);
		if (mirror.fails == 0 && mirror.due_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
